// File: rtl/u8dec_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by the front stage, back stage and top level.
package u8dec_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int ST_W   = 3;

   // result status codes; a corrupt sequence reports its own length
   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_INVALID  = 3'd1;
   localparam logic [ST_W-1:0] ST_CORRUPT2 = 3'd2;
   localparam logic [ST_W-1:0] ST_CORRUPT3 = 3'd3;
   localparam logic [ST_W-1:0] ST_CORRUPT4 = 3'd4;

   // byte classes as seen without sequence context
   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_CONT,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_INVALID
   } byte_class_type;

   typedef struct packed {
      byte_class_type    cls;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic [ST_W-1:0] status;
   } rsp_type;

endpackage

// File: rtl/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder: one byte per word in, one code point/status word out.
// A result passes through the front register, the command queue and the result queue before it shows on rsp_.
// Throughput: one byte per cycle while no queue is full; a full queue raises req_full and holds the input.
// Reset (synchronous, active high) empties both queues and drops any sequence
// in progress; the decoder then expects a lead byte.
// Depends on u8dec_pkg, u8dec_fifo, u8dec_front and u8dec_back.
module utf8_stream_decoder_unit
   import u8dec_pkg::*;
#(
   parameter int CMD_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [CP_W-1:0]   rsp_code_point,
   output logic [ST_W-1:0]   rsp_status
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   // front -> command queue
   logic             front_push;
   cmd_type          front_item;
   logic             cmd_full;
   // command queue -> back
   logic [CMD_W-1:0] cmd_head_bits;
   cmd_type          cmd_head;
   logic             cmd_empty;
   logic             cmd_pop;
   // back -> result queue
   logic             back_push;
   rsp_type          back_item;
   logic             rsp_full;
   logic [RSP_W-1:0] rsp_head_bits;
   rsp_type          rsp_head;

   // Classify each byte as it arrives and hold it in one register stage.
   u8dec_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_full      (req_full),
      .cmd_push      (front_push),
      .cmd_item      (front_item),
      .cmd_full      (cmd_full)
   );

   // Decouple classification from sequence tracking.
   u8dec_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_item),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head_bits),
      .empty     (cmd_empty)
   );

   assign cmd_head = cmd_type'(cmd_head_bits);

   // Advance the sequence state; emit a word for ASCII, a stray or invalid byte, or sequence end.
   u8dec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (back_push),
      .rsp_item  (back_item)
   );

   // Hold finished words until the consumer pops them.
   u8dec_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_item),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head_bits),
      .empty     (rsp_empty)
   );

   assign rsp_head       = rsp_type'(rsp_head_bits);
   assign rsp_code_point = rsp_head.code_point;
   assign rsp_status     = rsp_head.status;

endmodule

// File: rtl/u8dec_fifo.sv
// Small register-based first-in first-out queue with a count.
// Generic; no package dependency.
module u8dec_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fifo count exceeds depth");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> !empty)
      else $error("fifo empty after a lone push");

endmodule

// File: rtl/u8dec_front.sv
// Front stage: registers each incoming byte together with its class.
// Depends on u8dec_pkg for the byte class and command word types.
module u8dec_front
   import u8dec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              req_full,
   output logic              cmd_push,
   output cmd_type           cmd_item,
   input  logic              cmd_full
);

   function automatic byte_class_type classify(input logic [BYTE_W-1:0] b);
      priority if (b[7] == 1'b0)      return CLS_ASCII;
      else if (b[7:6] == 2'b10)       return CLS_CONT;
      else if (b[7:5] == 3'b110)      return CLS_LEAD2;
      else if (b[7:4] == 4'b1110)     return CLS_LEAD3;
      else if (b[7:3] == 5'b11110)    return CLS_LEAD4;
      else                            return CLS_INVALID;
   endfunction

   logic    valid_ff, valid_in;
   cmd_type item_ff, item_in;
   logic    accept;
   logic    advance;

   assign req_full = valid_ff & cmd_full;
   assign accept   = req_push & ~req_full;
   assign advance  = valid_ff & ~cmd_full;
   assign cmd_push = valid_ff;
   assign cmd_item = item_ff;

   always_comb begin
      valid_in = accept | (valid_ff & ~advance);
      item_in  = item_ff;
      if (accept) begin
         item_in.cls  = classify(req_data_byte);
         item_in.data = req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && cmd_full) |=> (valid_ff && $stable(item_ff)))
      else $error("front stage lost a stalled word");

endmodule

// File: rtl/u8dec_back.sv
// Back stage: tracks the multi-byte sequence and builds result words.
// Depends on u8dec_pkg for command/result types and status codes.
module u8dec_back
   import u8dec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd_head,
   input  logic    cmd_empty,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_item
);

   logic [1:0]      remain_ff, remain_in;
   logic [ST_W-1:0] seq_status_ff, seq_status_in;
   logic [CP_W-1:0] partial_ff, partial_in;
   logic            bad_ff, bad_in;
   logic            bad_next;
   logic [CP_W-1:0] partial_next;

   // take a word only when a result slot is guaranteed
   assign cmd_pop      = ~cmd_empty & ~rsp_full;
   assign bad_next     = bad_ff | (cmd_head.cls != CLS_CONT);
   assign partial_next = {partial_ff[CP_W-7:0], cmd_head.data[5:0]};

   always_comb begin
      remain_in     = remain_ff;
      seq_status_in = seq_status_ff;
      partial_in    = partial_ff;
      bad_in        = bad_ff;
      rsp_push      = 1'b0;
      rsp_item      = '{code_point: '0, status: ST_OK};
      if (cmd_pop) begin
         priority if (remain_ff != 2'd0) begin
            // any byte counts as a continuation here; wrong form only marks it
            remain_in  = remain_ff - 2'd1;
            partial_in = partial_next;
            bad_in     = bad_next;
            if (remain_ff == 2'd1) begin
               rsp_push = 1'b1;
               if (bad_next) begin
                  rsp_item = '{code_point: '0, status: seq_status_ff};
               end else begin
                  rsp_item = '{code_point: partial_next, status: ST_OK};
               end
               seq_status_in = ST_OK;
               partial_in    = '0;
               bad_in        = 1'b0;
            end
         end else begin
            unique case (cmd_head.cls)
               CLS_ASCII: begin
                  rsp_push = 1'b1;
                  rsp_item = '{code_point: CP_W'(cmd_head.data), status: ST_OK};
               end
               CLS_LEAD2: begin
                  remain_in     = 2'd1;
                  seq_status_in = ST_CORRUPT2;
                  partial_in    = CP_W'(cmd_head.data[4:0]);
                  bad_in        = 1'b0;
               end
               CLS_LEAD3: begin
                  remain_in     = 2'd2;
                  seq_status_in = ST_CORRUPT3;
                  partial_in    = CP_W'(cmd_head.data[3:0]);
                  bad_in        = 1'b0;
               end
               CLS_LEAD4: begin
                  remain_in     = 2'd3;
                  seq_status_in = ST_CORRUPT4;
                  partial_in    = CP_W'(cmd_head.data[2:0]);
                  bad_in        = 1'b0;
               end
               default: begin
                  // stray continuation or impossible lead
                  rsp_push = 1'b1;
                  rsp_item = '{code_point: '0, status: ST_INVALID};
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff     <= 2'd0;
         seq_status_ff <= ST_OK;
         partial_ff    <= '0;
         bad_ff        <= 1'b0;
      end else begin
         remain_ff     <= remain_in;
         seq_status_ff <= seq_status_in;
         partial_ff    <= partial_in;
         bad_ff        <= bad_in;
      end
   end

   a_push_needs_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> cmd_pop)
      else $error("result word without a command word");

   a_last_byte_emits: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && remain_ff == 2'd1) |-> rsp_push)
      else $error("sequence end produced no result");

   a_len_matches: assert property (@(posedge clock) disable iff (reset)
      (remain_ff == 2'd3) |-> (seq_status_ff == ST_CORRUPT4))
      else $error("four-byte count with wrong sequence length");

endmodule
